>>> hw/rtl/hurl_pkg.sv
// Shared types, constants and byte tables of the HTTP request URL locator.
package hurl_pkg;

    // Fixed sizes of the payload fields
    localparam int BYTE_W   = 8;
    localparam int OFS_W    = 11;
    localparam int LIMIT_W  = 12;
    localparam int STATUS_W = 3;
    localparam int PMC_W    = 3;

    // Defaults and protocol constants
    localparam int MAX_PACKET_BYTES_DEF = 2048;
    localparam int MIN_REQUEST_BYTES    = 18;
    localparam int MIN_LINE_BYTES       = 8;
    localparam int URL_LIMIT_RESET      = 512;
    localparam int URI_OFFSET           = 4;
    localparam int MARK_BACK            = 9;
    localparam int MARK_LEN             = 6;
    localparam int RECENT_DEPTH         = 9;
    localparam int QUEUE_DEPTH          = 2;

    localparam logic [BYTE_W-1:0] CR_BYTE = 8'h0D;
    localparam logic [BYTE_W-1:0] SP_BYTE = 8'h20;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK_HOST  = 3'd0,
        ST_OK_NO_HOST = 3'd1,
        ST_BAD_LINE = 3'd2,
        ST_URI_LONG = 3'd3,
        ST_HOST_LONG = 3'd4,
        ST_URL_LONG = 3'd5
    } status_t;

    // One input transaction
    typedef struct packed {
        byte_t data_byte;
        logic  end_of_request;
    } hurl_in_t;

    // One result transaction
    typedef struct packed {
        status_t           status;
        logic [OFS_W-1:0]  uri_start;
        logic [OFS_W-1:0]  uri_len;
        logic [OFS_W-1:0]  host_start;
        logic [OFS_W-1:0]  host_len;
        logic [OFS_W-1:0]  url_len;
    } hurl_out_t;

    // Byte classification passed from the front to the back
    typedef struct packed {
        byte_t data_byte;
        logic  is_cr;
        logic  is_sp;
        logic  far_sp;    // byte nine places back is a space
        logic  mark_ok;   // bytes nine to four places back read " HTTP/"
        logic  in_range;  // byte lies within the packet size
        logic  last;
    } hurl_cls_t;

    // " HTTP/" indexed from its first character
    function automatic byte_t http_mark_byte(input logic [PMC_W-1:0] idx);
        byte_t b;
        unique case (idx)
            3'd0:    b = 8'h20;
            3'd1:    b = 8'h48;
            3'd2:    b = 8'h54;
            3'd3:    b = 8'h54;
            3'd4:    b = 8'h50;
            3'd5:    b = 8'h2F;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // "Host: " indexed from its first character
    function automatic byte_t host_mark_byte(input logic [PMC_W-1:0] idx);
        byte_t b;
        unique case (idx)
            3'd0:    b = 8'h48;
            3'd1:    b = 8'h6F;
            3'd2:    b = 8'h73;
            3'd3:    b = 8'h74;
            3'd4:    b = 8'h3A;
            3'd5:    b = 8'h20;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> hw/rtl/hurl_front.sv
// Front end: accepts request bytes, tracks position and recent bytes, classifies each byte.
module hurl_front
    import hurl_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF,
    localparam int PW = $clog2(MAX_PACKET_BYTES + 2)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  hurl_in_t        in_data,
    output logic            push,
    input  logic            queue_ready,
    output logic [PW-1:0]   push_pos,
    output hurl_cls_t       push_cls
);

    logic [PW-1:0] pos_reg, pos_next;
    byte_t         recent_reg [RECENT_DEPTH];
    logic          in_range;
    logic          mark_ok;

    assign in_ready = queue_ready;
    assign push     = in_valid && queue_ready;
    assign in_range = pos_reg < PW'(MAX_PACKET_BYTES);

    // Compare the six bytes nine to four places back against " HTTP/"
    always_comb
    begin
        mark_ok = 1'b1;
        for (int k = 0; k < MARK_LEN; k++)
        begin
            if (recent_reg[RECENT_DEPTH - 1 - k] != http_mark_byte(PMC_W'(k)))
            begin
                mark_ok = 1'b0;
            end
        end
    end

    // Build the classified transaction
    always_comb
    begin
        push_pos          = pos_reg;
        push_cls.data_byte = in_data.data_byte;
        push_cls.is_cr    = in_data.data_byte == CR_BYTE;
        push_cls.is_sp    = in_data.data_byte == SP_BYTE;
        push_cls.far_sp   = recent_reg[RECENT_DEPTH - 1] == SP_BYTE;
        push_cls.mark_ok  = mark_ok;
        push_cls.in_range = in_range;
        push_cls.last     = in_data.end_of_request;
    end

    // Advance the position, restart after the last byte
    always_comb
    begin
        pos_next = pos_reg;
        if (push)
        begin
            if (in_data.end_of_request)
            begin
                pos_next = '0;
            end
            else if (in_range)
            begin
                pos_next = pos_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    // Shift the recent bytes, clear them after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < RECENT_DEPTH; k++)
            begin
                recent_reg[k] <= '0;
            end
        end
        else if (push)
        begin
            if (in_data.end_of_request)
            begin
                for (int k = 0; k < RECENT_DEPTH; k++)
                begin
                    recent_reg[k] <= '0;
                end
            end
            else if (in_range)
            begin
                recent_reg[0] <= in_data.data_byte;
                for (int k = 1; k < RECENT_DEPTH; k++)
                begin
                    recent_reg[k] <= recent_reg[k - 1];
                end
            end
        end
    end

endmodule

>>> hw/rtl/hurl_queue.sv
// Short FIFO between the front end and the back end.
module hurl_queue
    import hurl_pkg::*;
#(
    parameter int WIDTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem [QUEUE_DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;

    assign push_ready = count_reg != CNTW'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem[rd_ptr_reg];

    // Step pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNTW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming transaction
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hw/rtl/hurl_back.sv
// Back end: request line and header tracking, length checks and the result register.
module hurl_back
    import hurl_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF,
    localparam int PW = $clog2(MAX_PACKET_BYTES + 2)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop,
    input  logic [PW-1:0]      pop_pos,
    input  hurl_cls_t          pop_cls,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data,
    output logic               out_valid,
    input  logic               out_ready,
    output hurl_out_t          out_data
);

    localparam int CW = ((PW > LIMIT_W) ? PW : LIMIT_W) + 1;

    logic [LIMIT_W-1:0] limit_reg;

    // Tracking state
    logic              seen_reg, seen_next;
    logic              ok_reg, ok_next;
    logic [PW-1:0]     uf_reg, uf_next;
    logic [PW-1:0]     ul_reg, ul_next;
    logic [PW-1:0]     lb_reg, lb_next;
    logic              skip_reg, skip_next;
    logic [PMC_W-1:0]  pmc_reg, pmc_next;
    logic [PW-1:0]     hf_reg, hf_next;
    logic [PW-1:0]     hl_reg, hl_next;
    logic              found_reg, found_next;

    // Finish stage snapshot
    logic              f_valid_reg;
    logic              f_line_ok_reg;
    logic              f_host_ok_reg;
    logic [PW-1:0]     f_uf_reg, f_ul_reg, f_hf_reg, f_hl_reg;

    logic              out_valid_reg;
    hurl_out_t         out_data_reg;

    logic              o_free, f_adv, f_free, take;
    logic [PW-1:0]     pos, idx, off, total;
    logic [CW-1:0]     total_w, lb_w;
    logic              line_ok_next, host_ok_next;

    assign cfg_ready = 1'b1;
    assign o_free    = !out_valid_reg || out_ready;
    assign f_adv     = f_valid_reg && o_free;
    assign f_free    = !f_valid_reg || f_adv;
    assign pop       = pop_valid && (!pop_cls.last || f_free);
    assign take      = pop && pop_cls.in_range;
    assign pos       = pop_pos;
    assign idx       = pos - PW'(MARK_BACK);
    assign off       = pos - lb_reg;
    assign total     = pop_cls.in_range ? pos + PW'(1) : pos;
    assign total_w   = CW'(total);
    assign lb_w      = CW'(lb_reg);

    // Hold the URL limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_W'(URL_LIMIT_RESET);
        end
        else if (cfg_valid)
        begin
            limit_reg <= cfg_data;
        end
    end

    // Update tracking state for one byte
    always_comb
    begin
        seen_next  = seen_reg;
        ok_next    = ok_reg;
        uf_next    = uf_reg;
        ul_next    = ul_reg;
        lb_next    = lb_reg;
        skip_next  = skip_reg;
        pmc_next   = pmc_reg;
        hf_next    = hf_reg;
        hl_next    = hl_reg;
        found_next = found_reg;
        if (take)
        begin
            if (!seen_reg)
            begin
                if (pop_cls.is_cr)
                begin
                    seen_next = 1'b1;
                    ok_next   = (pos >= PW'(MARK_BACK)) && pop_cls.mark_ok;
                    if (pos < PW'(URI_OFFSET + MARK_BACK + 1))
                    begin
                        uf_next = PW'(URI_OFFSET);
                        ul_next = PW'(URI_OFFSET);
                    end
                    lb_next   = pos + PW'(2);
                    skip_next = 1'b1;
                    pmc_next  = '0;
                end
                else if (pos >= PW'(URI_OFFSET + MARK_BACK))
                begin
                    if (idx == PW'(URI_OFFSET))
                    begin
                        uf_next = pop_cls.far_sp ? idx + PW'(1) : idx;
                    end
                    else if (pop_cls.far_sp && uf_reg == idx)
                    begin
                        uf_next = idx + PW'(1);
                    end
                    if (!pop_cls.far_sp)
                    begin
                        ul_next = idx + PW'(1);
                    end
                end
            end
            else if (ok_reg && !found_reg)
            begin
                if (skip_reg)
                begin
                    skip_next = 1'b0;
                end
                else if (pop_cls.is_cr)
                begin
                    if (pmc_reg == PMC_W'(MARK_LEN))
                    begin
                        found_next = 1'b1;
                    end
                    else
                    begin
                        lb_next   = pos + PW'(2);
                        skip_next = 1'b1;
                        pmc_next  = '0;
                    end
                end
                else if (off < PW'(MARK_LEN))
                begin
                    if (pmc_reg == off[PMC_W-1:0]
                        && pop_cls.data_byte == host_mark_byte(off[PMC_W-1:0]))
                    begin
                        pmc_next = pmc_reg + PMC_W'(1);
                        if (pmc_reg == PMC_W'(MARK_LEN - 1))
                        begin
                            hf_next = pos + PW'(1);
                            hl_next = pos + PW'(1);
                        end
                    end
                end
                else if (pmc_reg == PMC_W'(MARK_LEN))
                begin
                    if (pop_cls.is_sp && hf_reg == pos)
                    begin
                        hf_next = pos + PW'(1);
                    end
                    if (!pop_cls.is_sp)
                    begin
                        hl_next = pos + PW'(1);
                    end
                end
            end
        end
    end

    // Judge request line and host line validity at the last byte
    assign line_ok_next = seen_next && ok_next && (total >= PW'(MIN_REQUEST_BYTES));
    assign host_ok_next = found_next && (total_w >= lb_w + CW'(MIN_LINE_BYTES));

    // Advance tracking state, clear it after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= 1'b0;
            ok_reg    <= 1'b0;
            uf_reg    <= '0;
            ul_reg    <= '0;
            lb_reg    <= '0;
            skip_reg  <= 1'b0;
            pmc_reg   <= '0;
            hf_reg    <= '0;
            hl_reg    <= '0;
            found_reg <= 1'b0;
        end
        else if (pop && pop_cls.last)
        begin
            seen_reg  <= 1'b0;
            ok_reg    <= 1'b0;
            uf_reg    <= '0;
            ul_reg    <= '0;
            lb_reg    <= '0;
            skip_reg  <= 1'b0;
            pmc_reg   <= '0;
            hf_reg    <= '0;
            hl_reg    <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            seen_reg  <= seen_next;
            ok_reg    <= ok_next;
            uf_reg    <= uf_next;
            ul_reg    <= ul_next;
            lb_reg    <= lb_next;
            skip_reg  <= skip_next;
            pmc_reg   <= pmc_next;
            hf_reg    <= hf_next;
            hl_reg    <= hl_next;
            found_reg <= found_next;
        end
    end

    // Capture the final state of a request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (pop && pop_cls.last)
        begin
            f_valid_reg <= 1'b1;
        end
        else if (f_adv)
        begin
            f_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && pop_cls.last)
        begin
            f_line_ok_reg <= line_ok_next;
            f_host_ok_reg <= host_ok_next;
            f_uf_reg      <= uf_next;
            f_ul_reg      <= ul_next;
            f_hf_reg      <= hf_next;
            f_hl_reg      <= hl_next;
        end
    end

    // Compute lengths and status from the snapshot
    logic [CW-1:0] uf_w, ul_w, hf_w, hl_w, ulen_w, hlen_w, sum_w, limit_w;
    hurl_out_t     res;

    always_comb
    begin
        uf_w    = CW'(f_uf_reg);
        ul_w    = CW'(f_ul_reg);
        hf_w    = CW'(f_hf_reg);
        hl_w    = CW'(f_hl_reg);
        limit_w = CW'(limit_reg);
        ulen_w  = (ul_w > uf_w) ? ul_w - uf_w : '0;
        hlen_w  = (hl_w > hf_w) ? hl_w - hf_w : '0;
        sum_w   = ulen_w + hlen_w;

        res            = '0;
        res.status     = ST_BAD_LINE;
        if (f_line_ok_reg)
        begin
            res.uri_start = uf_w[OFS_W-1:0];
            res.uri_len   = ulen_w[OFS_W-1:0];
            if (ulen_w >= limit_w)
            begin
                res.status = ST_URI_LONG;
            end
            else if (f_host_ok_reg)
            begin
                res.host_start = hf_w[OFS_W-1:0];
                res.host_len   = hlen_w[OFS_W-1:0];
                res.url_len    = sum_w[OFS_W-1:0];
                if (hlen_w >= limit_w)
                begin
                    res.status = ST_HOST_LONG;
                end
                else if (sum_w >= limit_w)
                begin
                    res.status = ST_URL_LONG;
                end
                else
                begin
                    res.status = ST_OK_HOST;
                end
            end
            else
            begin
                res.status  = ST_OK_NO_HOST;
                res.url_len = ulen_w[OFS_W-1:0];
            end
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (f_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_adv)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> hw/rtl/http_request_url_locator.sv
// Top level of the HTTP request URL locator.
//
// Usage:
//   in channel  (in_valid/in_ready/in_data): one request byte per transaction,
//     end_of_request set on the final byte of the request.
//   out channel (out_valid/out_ready/out_data): one result per request,
//     carrying status and the trimmed URI and host offsets and lengths.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): writes url_limit; always ready,
//     to be written only while no request is in flight.
// Throughput: one byte per cycle while the queue has room; the back end byte
//   tracker updates its counters and flags for one popped byte each cycle.
// Result path: the final byte passes through the queue, the snapshot stage
//   and the result register before its result becomes valid.
// Reset: clears the queue, all tracking state and the result register, and
//   sets url_limit to 512.
// Stall: a waiting result holds in its register while the next request streams
//   in; only a second final byte waits until the snapshot stage frees up, and
//   the two-entry queue then fills and drops in_ready.
module http_request_url_locator
    import hurl_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  hurl_in_t           in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output hurl_out_t          out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data
);

    localparam int PW = $clog2(MAX_PACKET_BYTES + 2);
    localparam int QW = PW + $bits(hurl_cls_t);

    logic            push, queue_ready, pop_valid, pop;
    logic [PW-1:0]   push_pos, pop_pos;
    hurl_cls_t       push_cls, pop_cls;
    logic [QW-1:0]   pop_word;

    // Classify incoming bytes
    hurl_front #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .push        (push),
        .queue_ready (queue_ready),
        .push_pos    (push_pos),
        .push_cls    (push_cls)
    );

    // Decouple front and back
    hurl_queue #(
        .WIDTH(QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (queue_ready),
        .push_data  ({push_pos, push_cls}),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_data   (pop_word)
    );

    assign pop_pos = pop_word[QW-1 -: PW];
    assign pop_cls = pop_word[$bits(hurl_cls_t)-1:0];

    // Track the request and produce the result
    hurl_back #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_pos   (pop_pos),
        .pop_cls   (pop_cls),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> sim/http_request_url_locator_test.sv
// Self-checking testbench of the HTTP request URL locator: request streams against a byte-level predictor.
module http_request_url_locator_test;
    import hurl_pkg::*;

    localparam int          SETTLE_CYCLES = 8;
    localparam int          HOLD_CYCLES   = 300;
    localparam int unsigned QUIET_LIMIT   = 3000;
    localparam int          MAX_REPORTS   = 10;

    localparam byte_t       LF_BYTE   = 8'h0A;
    localparam logic [47:0] HTTP_MARK = " HTTP/";
    localparam logic [47:0] HOST_MARK = "Host: ";

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    hurl_in_t           in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    hurl_out_t          out_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data = '0;

    http_request_url_locator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Free-running clock, period 10
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor copy of the limit register and the per-request tracking state
    logic [LIMIT_W-1:0] limit_now;
    logic [11:0]        byte_pos;
    logic [11:0]        uri_first;
    logic [11:0]        uri_last;
    logic [11:0]        line_start;
    logic [11:0]        host_first;
    logic [11:0]        host_last;
    logic [PMC_W-1:0]   match_cnt;
    logic               line_seen;
    logic               line_ok;
    logic               host_found;
    logic               skip_next;
    byte_t              recent [RECENT_DEPTH];

    hurl_in_t  byte_feed [$];
    hurl_out_t expected_locations [$];

    int unsigned requests_sent = 0;
    int unsigned bytes_sent = 0;
    int unsigned limit_settings = 0;
    int unsigned results_checked = 0;
    int unsigned fault_count = 0;
    int unsigned hold_ticket = 0;
    bit          sender_gaps = 1'b1;
    bit          receiver_stalls = 1'b1;

    // Clear the tracking state, as after every result
    task automatic clear_tracking();
        byte_pos   = '0;
        uri_first  = '0;
        uri_last   = '0;
        line_start = '0;
        host_first = '0;
        host_last  = '0;
        match_cnt  = '0;
        line_seen  = 1'b0;
        line_ok    = 1'b0;
        host_found = 1'b0;
        skip_next  = 1'b0;
        foreach (recent[k])
            recent[k] = '0;
    endtask

    // Track the request line: check the protocol mark at the first CR, trim the URI
    task automatic track_request_line(input byte_t b);
        logic [11:0] i;
        if (b == CR_BYTE)
        begin
            line_seen = 1'b1;
            line_ok = (byte_pos >= MARK_BACK);
            for (int k = 0; k < MARK_LEN; k++)
                if (recent[RECENT_DEPTH-1-k] != HTTP_MARK[8*(MARK_LEN-1-k) +: 8])
                    line_ok = 1'b0;
            if (byte_pos < URI_OFFSET + MARK_BACK + 1)
            begin
                uri_first = URI_OFFSET;
                uri_last  = URI_OFFSET;
            end
            line_start = byte_pos + 12'd2;
            skip_next  = 1'b1;
            match_cnt  = '0;
        end
        else if (byte_pos >= URI_OFFSET + MARK_BACK)
        begin
            // the byte nine back is settled to lie inside the URI span
            i = byte_pos - MARK_BACK;
            if (i == URI_OFFSET)
                uri_first = (recent[RECENT_DEPTH-1] == SP_BYTE) ? i + 12'd1 : i;
            else if (recent[RECENT_DEPTH-1] == SP_BYTE && uri_first == i)
                uri_first = i + 12'd1;
            if (recent[RECENT_DEPTH-1] != SP_BYTE)
                uri_last = i + 12'd1;
        end
    endtask

    // Track header lines: look for the first line that starts with the host mark
    task automatic track_header(input byte_t b);
        int unsigned off;
        if (skip_next)
            skip_next = 1'b0;
        else
        begin
            off = byte_pos - line_start;
            if (b == CR_BYTE)
            begin
                if (match_cnt == MARK_LEN)
                    host_found = 1'b1;
                else
                begin
                    line_start = byte_pos + 12'd2;
                    skip_next  = 1'b1;
                    match_cnt  = '0;
                end
            end
            else if (off < MARK_LEN)
            begin
                if (match_cnt == off && b == HOST_MARK[8*(MARK_LEN-1-off) +: 8])
                begin
                    match_cnt = match_cnt + 1'b1;
                    if (match_cnt == MARK_LEN)
                    begin
                        host_first = byte_pos + 12'd1;
                        host_last  = byte_pos + 12'd1;
                    end
                end
            end
            else if (match_cnt == MARK_LEN)
            begin
                if (b == SP_BYTE && host_first == byte_pos)
                    host_first = byte_pos + 12'd1;
                if (b != SP_BYTE)
                    host_last = byte_pos + 12'd1;
            end
        end
    endtask

    // Advance the predictor by one accepted byte; on the final byte queue the expected result
    task automatic locate_byte(input hurl_in_t item);
        int unsigned total;
        int unsigned ulen;
        int unsigned hlen;
        int unsigned sum;
        hurl_out_t   res;
        if (byte_pos < MAX_PACKET_BYTES_DEF)
        begin
            if (!line_seen)
                track_request_line(item.data_byte);
            else if (line_ok && !host_found)
                track_header(item.data_byte);
            for (int k = RECENT_DEPTH - 1; k > 0; k--)
                recent[k] = recent[k-1];
            recent[0] = item.data_byte;
            byte_pos = byte_pos + 12'd1;
        end
        if (item.end_of_request)
        begin
            res = '0;
            total = byte_pos;
            if (!line_seen || !line_ok || total < MIN_REQUEST_BYTES)
                res.status = ST_BAD_LINE;
            else
            begin
                ulen = (uri_last > uri_first) ? uri_last - uri_first : 0;
                res.uri_start = uri_first[OFS_W-1:0];
                res.uri_len   = ulen[OFS_W-1:0];
                if (ulen >= limit_now)
                    res.status = ST_URI_LONG;
                else if (host_found && total >= line_start + MIN_LINE_BYTES)
                begin
                    hlen = (host_last > host_first) ? host_last - host_first : 0;
                    sum  = hlen + ulen;
                    res.host_start = host_first[OFS_W-1:0];
                    res.host_len   = hlen[OFS_W-1:0];
                    res.url_len    = sum[OFS_W-1:0];
                    if (hlen >= limit_now)
                        res.status = ST_HOST_LONG;
                    else if (sum >= limit_now)
                        res.status = ST_URL_LONG;
                    else
                        res.status = ST_OK_HOST;
                end
                else
                begin
                    res.status  = ST_OK_NO_HOST;
                    res.url_len = ulen[OFS_W-1:0];
                end
            end
            expected_locations.push_back(res);
            clear_tracking();
        end
    endtask

    // Gap length: mostly none or short, a few long
    function automatic int unsigned draw_gap();
        int unsigned r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Driver: offer queued bytes, predict each accepted transaction
    int unsigned send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                locate_byte(in_data);
            // hold the payload until accepted, then idle or advance
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (byte_feed.size() != 0)
                begin
                    in_data  <= byte_feed.pop_front();
                    in_valid <= 1'b1;
                    send_gap = sender_gaps ? draw_gap() : 0;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Compare one result transaction with the oldest expected location
    task automatic check_result(input hurl_out_t got);
        hurl_out_t want;
        bit        bad;
        if (expected_locations.size() == 0)
        begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
                $display("unexpected result: status %0d uri %0d/%0d host %0d/%0d url %0d",
                         got.status, got.uri_start, got.uri_len, got.host_start,
                         got.host_len, got.url_len);
        end
        else
        begin
            want = expected_locations.pop_front();
            results_checked++;
            bad = (got.status !== want.status) || (got.uri_start !== want.uri_start) ||
                  (got.uri_len !== want.uri_len) || (got.host_start !== want.host_start) ||
                  (got.host_len !== want.host_len) || (got.url_len !== want.url_len);
            if (bad)
            begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                begin
                    $display("result %0d mismatch, expected: status %0d uri %0d/%0d host %0d/%0d url %0d",
                             results_checked, want.status, want.uri_start, want.uri_len,
                             want.host_start, want.host_len, want.url_len);
                    $display("  actual:   status %0d uri %0d/%0d host %0d/%0d url %0d",
                             got.status, got.uri_start, got.uri_len, got.host_start,
                             got.host_len, got.url_len);
                end
            end
        end
    endtask

    // Monitor: check results, stall at random, hold off on request
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned hold_seen;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
            hold_seen  = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result(out_data);
            if (hold_ticket != hold_seen)
            begin
                hold_seen = hold_ticket;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (receiver_stalls && $urandom_range(0, 3) == 0)
                    stall_left = draw_gap();
            end
        end
    end

    // Watchdog: end the run after a long stretch without any transaction
    int unsigned quiet_cycles = 0;
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Append text; '|' stands for a carriage return
    task automatic add_text(ref byte_t r[$], input string s);
        for (int k = 0; k < s.len(); k++)
            r.push_back((s[k] == "|") ? CR_BYTE : byte_t'(s[k]));
    endtask

    // Append n token bytes: never a space or a CR, now and then a high byte
    task automatic add_chars(ref byte_t r[$], input int n);
        repeat (n)
            r.push_back(($urandom_range(0, 15) == 0) ? byte_t'($urandom_range(8'h80, 8'hFF))
                                                     : byte_t'($urandom_range(8'h21, 8'h7E)));
    endtask

    // Append zero to three spaces
    task automatic add_pad(ref byte_t r[$]);
        if ($urandom_range(0, 1) != 0)
            repeat ($urandom_range(1, 3))
                r.push_back(SP_BYTE);
    endtask

    // End a line: CR, then the skipped byte, usually LF
    task automatic end_line(ref byte_t r[$], input bit plain);
        r.push_back(CR_BYTE);
        r.push_back((plain || $urandom_range(0, 7) != 0) ? LF_BYTE
                                                          : byte_t'($urandom_range(0, 255)));
    endtask

    // Append a header line that is not a valid host line, some of them near misses
    task automatic add_filler(ref byte_t r[$]);
        case ($urandom_range(0, 3))
            0: add_text(r, "Hostname: ");
            1: add_text(r, "host: ");
            2: add_text(r, "Host:");
            default:
            begin
                add_text(r, "X-");
                add_chars(r, $urandom_range(1, 4));
                add_text(r, ": ");
            end
        endcase
        add_chars(r, $urandom_range(0, 6));
        end_line(r, 1'b0);
    endtask

    // Build a mostly well-formed request; host_n below zero leaves out the host line
    task automatic make_request(ref byte_t r[$], input int uri_n, input int host_n,
                                input bit plain);
        int unsigned lines_ahead;
        int unsigned lines_after;
        r.delete();
        lines_ahead = plain ? 0 : $urandom_range(0, 2);
        lines_after = plain ? 0 : $urandom_range(0, 1);
        if (plain)
            add_text(r, "GET ");
        else
            case ($urandom_range(0, 3))
                0:       add_text(r, "GET ");
                1:       add_text(r, "POST ");
                2:       add_text(r, "DELETE ");
                default: add_chars(r, 4);
            endcase
        if (!plain)
            add_pad(r);
        add_chars(r, uri_n);
        if (!plain)
            add_pad(r);
        if (plain || $urandom_range(0, 11) != 0)
            add_text(r, " HTTP/1.1");
        else
            add_text(r, " http/1.1");
        end_line(r, plain);
        repeat (lines_ahead)
            add_filler(r);
        if (host_n >= 0)
        begin
            add_text(r, "Host: ");
            if (!plain)
                add_pad(r);
            add_chars(r, host_n);
            if (!plain)
                add_pad(r);
            end_line(r, plain);
        end
        repeat (lines_after)
            add_filler(r);
        if (plain || $urandom_range(0, 4) != 0)
            end_line(r, plain);
        if (!plain)
            add_chars(r, $urandom_range(0, 3));
    endtask

    // Queue one request for the driver, end mark on its final byte
    task automatic queue_request(ref byte_t r[$]);
        hurl_in_t item;
        foreach (r[k])
        begin
            item.data_byte = r[k];
            item.end_of_request = (k == r.size() - 1);
            byte_feed.push_back(item);
        end
        requests_sent++;
        bytes_sent += r.size();
    endtask

    task automatic send_text(input string s);
        byte_t r[$];
        add_text(r, s);
        queue_request(r);
    endtask

    task automatic send_plain(input int uri_n, input int host_n);
        byte_t r[$];
        make_request(r, uri_n, host_n, 1'b1);
        queue_request(r);
    endtask

    // Queue random requests: mostly well-formed, some cut short or corrupted, some noise
    task automatic random_batch(input int count);
        byte_t       r[$];
        int unsigned kind;
        int          uri_n;
        int          host_n;
        repeat (count)
        begin
            kind   = $urandom_range(0, 19);
            uri_n  = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 90) : $urandom_range(0, 20);
            host_n = ($urandom_range(0, 3) == 0) ? -1 : $urandom_range(0, 24);
            if (kind < 2)
            begin
                r.delete();
                repeat ($urandom_range(1, 40))
                    r.push_back(byte_t'($urandom_range(0, 255)));
            end
            else
            begin
                make_request(r, uri_n, host_n, 1'b0);
                if (kind == 2)
                    r = r[0:$urandom_range(0, r.size() - 1)];
                else if (kind == 3)
                    r[$urandom_range(0, r.size() - 1)] = byte_t'($urandom_range(0, 255));
            end
            queue_request(r);
        end
    endtask

    // Wait until every byte is accepted and every result is back, then let the pipe drain
    task automatic settle();
        while (byte_feed.size() != 0 || in_valid || expected_locations.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // Write the limit register through its channel
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        limit_now = value;
        limit_settings++;
        @(negedge clk);
    endtask

    // Stimulus sequence
    initial
    begin
        byte_t       r[$];
        int unsigned base_bytes;
        int unsigned base_requests;

        limit_now = URL_LIMIT_RESET;
        clear_tracking();
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed requests at the reset limit
        send_text("GET / HTTP/1.1|\n|\n");
        send_text("GET / HTTP/1.1|\nX");
        send_text("GET /index.html HTTP/1.1|\nHost: example.org|\n|\n");
        send_text("GET   /a b   HTTP/1.0|\nUser: q|\nHost:   h.io  |\nAccept: x|\n|\n");
        send_text("GET /sp HTTP/1.1|\nHost:      |\n|\n");
        send_text("GET /late HTTP/1.1|\nHost: |");
        send_text("GET /x HTTP/1.1|\nHost: abc");
        send_text("GET /y HTTP/1.1|\nHost: first|\nHost: second|\n|\n");
        send_text("GET HTTP/1.1|\nA: bcd|\n|\n");
        send_text("GETX HTTP/1.1|\nA: b|\n|\n");
        send_text("GET      HTTP/1.1|\n|\n");
        send_text("GET|\nHost: abcdefgh|\n|\n");
        send_text("GET / HTXP/1.1|\n|\nHost: a|\n|\n");
        send_text("GET /s HTTP/1.1|ZHost: z|\n|\n");
        send_text("GET /s HTTP/1.1||Host: zz|\n|\n");
        r.delete();
        add_chars(r, 30);
        queue_request(r);
        r.delete();
        r.push_back(8'hFF);
        queue_request(r);
        r.delete();
        add_text(r, "GET /");
        r.push_back(8'h00);
        r.push_back(8'hFF);
        r.push_back(8'h80);
        r.push_back(8'h7F);
        add_text(r, " HTTP/1.1|\nHost: ");
        r.push_back(8'hFF);
        r.push_back(8'h00);
        add_text(r, "|\n|\n");
        queue_request(r);
        send_plain(511, -1);
        send_plain(512, -1);
        send_plain(20, 600);
        send_plain(300, 300);
        send_plain(300, 211);
        settle();

        // smallest limit: only empty lengths pass
        write_limit(12'd1);
        send_text("GET HTTP/1.1|\nHost:  |\n|\n");
        send_plain(1, -1);
        random_batch(4);
        settle();

        // zero limit: every good request is too long
        write_limit(12'd0);
        send_text("GET HTTP/1.1|\nA: bcd|\n|\n");
        random_batch(4);
        settle();

        // largest sensible limit, longest URI and an overlong request
        write_limit(12'd2048);
        send_plain(2030, -1);
        make_request(r, 100, 30, 1'b1);
        repeat (2000)
            r.push_back(byte_t'($urandom_range(0, 255)));
        queue_request(r);
        random_batch(4);
        settle();

        // all ones in the register
        write_limit(12'hFFF);
        send_plain(2030, -1);
        random_batch(4);
        settle();

        // hold results back while short requests keep coming, so the input stalls
        write_limit(URL_LIMIT_RESET);
        sender_gaps = 1'b0;
        hold_ticket++;
        repeat (20)
            send_plain($urandom_range(1, 3), -1);
        settle();
        sender_gaps = 1'b1;

        // random phases under changing limits
        base_bytes    = bytes_sent;
        base_requests = requests_sent;
        while (bytes_sent - base_bytes < 450 || requests_sent - base_requests < 48)
        begin
            case ($urandom_range(0, 5))
                0:       write_limit($urandom_range(1, 30));
                1:       write_limit(12'd2048);
                2:       write_limit($urandom_range(1, 2048));
                3:       write_limit(12'hFFF);
                4:       write_limit(URL_LIMIT_RESET);
                default: write_limit(12'd0);
            endcase
            sender_gaps     = ($urandom_range(0, 3) != 0);
            receiver_stalls = ($urandom_range(0, 3) != 0);
            random_batch(8);
            settle();
        end

        $display("Run covered %0d requests (%0d bytes) under %0d limit settings,",
                 requests_sent, bytes_sent, limit_settings);
        $display("with random gaps on both sides and one long result hold-off; %0d results checked.",
                 results_checked);
        if (fault_count == 0 && expected_locations.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
